@@ hdl/hiq_pkg.sv @@
// Shared types and constants for the indexed min-heap queue.
package hiq_pkg;

	localparam int ID_BITS = 8;
	localparam int IN_W_BITS = 32;
	localparam int ACT_BITS = 3;
	localparam int QDEPTH = 2;

	localparam logic [ACT_BITS-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_BITS-1:0] ACT_APPEND = 3'd1;
	localparam logic [ACT_BITS-1:0] ACT_HEAPIFY = 3'd2;
	localparam logic [ACT_BITS-1:0] ACT_POP = 3'd3;
	localparam logic [ACT_BITS-1:0] ACT_PEEK = 3'd4;
	localparam logic [ACT_BITS-1:0] ACT_DECREASE = 3'd5;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_APPEND,
		OP_HEAPIFY,
		OP_POP,
		OP_PEEK,
		OP_DECREASE,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL = 3'd2,
		ST_INCREASE = 3'd3,
		ST_ABSENT = 3'd4
	} status_t;

	typedef struct packed {
		op_t op;
		logic id_ok;
		logic [ID_BITS-1:0] id;
		logic [IN_W_BITS-1:0] weight;
	} item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_DN,
		S_DN_K,
		S_DN_R,
		S_HF_RD,
		S_HF_LD,
		S_PK,
		S_PP_LD,
		S_DC_POS,
		S_DC_CHK,
		S_FIN
	} state_t;

endpackage

@@ hdl/hiq_front.sv @@
// Front end: takes command beats, classifies them and queues them for the back end.
module hiq_front #(
	parameter int ID_COUNT = 256
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [hiq_pkg::ACT_BITS-1:0] action,
	input logic [hiq_pkg::ID_BITS-1:0] entry_id,
	input logic [hiq_pkg::IN_W_BITS-1:0] weight,
	output logic busy,
	output hiq_pkg::item_t item,
	output logic item_valid,
	input logic item_take
);
	localparam int PTR_BITS = $clog2(hiq_pkg::QDEPTH);
	localparam int FILL_BITS = $clog2(hiq_pkg::QDEPTH + 1);

	hiq_pkg::item_t mem_q [hiq_pkg::QDEPTH];
	hiq_pkg::item_t new_item;
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [FILL_BITS-1:0] fill_q;
	logic push;
	logic pop;

	always_comb begin
		case (action)
			hiq_pkg::ACT_INSERT: new_item.op = hiq_pkg::OP_INSERT;
			hiq_pkg::ACT_APPEND: new_item.op = hiq_pkg::OP_APPEND;
			hiq_pkg::ACT_HEAPIFY: new_item.op = hiq_pkg::OP_HEAPIFY;
			hiq_pkg::ACT_POP: new_item.op = hiq_pkg::OP_POP;
			hiq_pkg::ACT_PEEK: new_item.op = hiq_pkg::OP_PEEK;
			hiq_pkg::ACT_DECREASE: new_item.op = hiq_pkg::OP_DECREASE;
			default: new_item.op = hiq_pkg::OP_NONE;
		endcase
		new_item.id_ok = 32'(entry_id) < ID_COUNT;
		new_item.id = entry_id;
		new_item.weight = weight;
	end

	assign busy = fill_q == FILL_BITS'(hiq_pkg::QDEPTH);
	assign push = start && !busy;
	assign item_valid = fill_q != '0;
	assign pop = item_take && item_valid;
	assign item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			fill_q <= fill_q + FILL_BITS'(push) - FILL_BITS'(pop);
		end
	end

endmodule

@@ hdl/hiq_back.sv @@
// Back end: heap store, position map and the sequencer that carries out each beat.
module hiq_back #(
	parameter int CAPACITY = 256,
	parameter int ID_COUNT = 256,
	parameter int WEIGHT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input hiq_pkg::item_t item,
	input logic item_valid,
	output logic item_take,
	output logic done,
	output logic [2:0] status,
	output logic [hiq_pkg::ID_BITS-1:0] out_id,
	output logic [hiq_pkg::IN_W_BITS-1:0] out_weight,
	output logic [$clog2(CAPACITY+1)-1:0] count,
	output logic is_empty
);
	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IDW = $clog2(ID_COUNT);
	localparam int WB = WEIGHT_BITS;
	localparam int IB = hiq_pkg::ID_BITS;

	logic [IB-1:0] hid_mem [CAPACITY];
	logic [WB-1:0] hw_mem [CAPACITY];
	logic [PW-1:0] pm_mem [ID_COUNT];
	logic [IB-1:0] hid_rd_q;
	logic [WB-1:0] hw_rd_q;
	logic [PW-1:0] pm_rd_q;

	hiq_pkg::state_t state_q;
	hiq_pkg::state_t state_d;
	hiq_pkg::status_t stat_q;
	logic [CW-1:0] cnt_q;
	logic [ID_COUNT-1:0] present_q;
	logic hf_q;
	logic is_pop_q;
	logic [PW-1:0] hi_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] start_q;
	logic [IB-1:0] cur_id_q;
	logic [WB-1:0] cur_w_q;
	logic [IB-1:0] kd_id_q;
	logic [WB-1:0] kd_w_q;
	logic [IB-1:0] oid_q;
	logic [WB-1:0] ow_q;

	logic [63:0] w64;
	logic [63:0] ow64;
	logic [WB-1:0] w_in;
	logic [IDW-1:0] iid;
	logic [PW-1:0] par;
	logic [PW+1:0] kid;
	logic [PW+1:0] right;
	logic [PW+1:0] cnt_x;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] half;
	logic kid_in;
	logic right_in;
	logic take_right;
	logic up_less;
	logic full;
	logic sift_end;
	hiq_pkg::state_t after_sift;

	logic [PW-1:0] hp_raddr;
	logic [IDW-1:0] pm_raddr;
	logic hp_we;
	logic [PW-1:0] hp_waddr;
	logic [IB-1:0] hp_wid;
	logic [WB-1:0] hp_ww;

	assign w64 = 64'(item.weight);
	assign w_in = w64[WB-1:0];
	assign iid = IDW'(item.id);
	assign par = (pos_q - PW'(1)) >> 1;
	assign kid = {1'b0, pos_q, 1'b1};
	assign right = kid + (PW+2)'(1);
	assign cnt_x = (PW+2)'(cnt_q);
	assign cnt_m1 = cnt_q - CW'(1);
	assign half = cnt_q >> 1;
	assign kid_in = kid < cnt_x;
	assign right_in = right < cnt_x;
	assign take_right = !(kd_w_q < hw_rd_q);
	assign up_less = cur_w_q < hw_rd_q;
	assign full = cnt_q >= CW'(CAPACITY);
	assign sift_end = (state_q == hiq_pkg::S_UP && !(pos_q > start_q)) ||
		(state_q == hiq_pkg::S_UP_CMP && !up_less);
	assign after_sift = (hf_q && hi_q != '0) ? hiq_pkg::S_HF_RD : hiq_pkg::S_FIN;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hiq_pkg::S_IDLE: begin
				if (item_valid) begin
					state_d = hiq_pkg::S_FIN;
					case (item.op)
						hiq_pkg::OP_INSERT: begin
							if (item.id_ok && !full) begin
								state_d = hiq_pkg::S_UP;
							end
						end
						hiq_pkg::OP_HEAPIFY: begin
							if (cnt_q != '0) begin
								state_d = hiq_pkg::S_HF_RD;
							end
						end
						hiq_pkg::OP_POP, hiq_pkg::OP_PEEK: begin
							if (cnt_q != '0) begin
								state_d = hiq_pkg::S_PK;
							end
						end
						hiq_pkg::OP_DECREASE: begin
							if (item.id_ok && present_q[iid]) begin
								state_d = hiq_pkg::S_DC_POS;
							end
						end
						default: state_d = hiq_pkg::S_FIN;
					endcase
				end
			end
			hiq_pkg::S_HF_RD: state_d = hiq_pkg::S_HF_LD;
			hiq_pkg::S_HF_LD: state_d = hiq_pkg::S_DN;
			hiq_pkg::S_DN: state_d = kid_in ? hiq_pkg::S_DN_K : hiq_pkg::S_UP;
			hiq_pkg::S_DN_K: state_d = right_in ? hiq_pkg::S_DN_R : hiq_pkg::S_DN;
			hiq_pkg::S_DN_R: state_d = hiq_pkg::S_DN;
			hiq_pkg::S_UP: state_d = (pos_q > start_q) ? hiq_pkg::S_UP_CMP : after_sift;
			hiq_pkg::S_UP_CMP: state_d = up_less ? hiq_pkg::S_UP : after_sift;
			hiq_pkg::S_PK: begin
				state_d = (is_pop_q && cnt_m1 != '0) ? hiq_pkg::S_PP_LD : hiq_pkg::S_FIN;
			end
			hiq_pkg::S_PP_LD: state_d = hiq_pkg::S_DN;
			hiq_pkg::S_DC_POS: begin
				state_d = (CW'(pm_rd_q) >= cnt_q) ? hiq_pkg::S_FIN : hiq_pkg::S_DC_CHK;
			end
			hiq_pkg::S_DC_CHK: begin
				if (hid_rd_q != cur_id_q || cur_w_q > hw_rd_q) begin
					state_d = hiq_pkg::S_FIN;
				end else begin
					state_d = hiq_pkg::S_UP;
				end
			end
			hiq_pkg::S_FIN: state_d = hiq_pkg::S_IDLE;
			default: state_d = hiq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		item_take = 1'b0;
		hp_raddr = '0;
		pm_raddr = iid;
		hp_we = 1'b0;
		hp_waddr = pos_q;
		hp_wid = cur_id_q;
		hp_ww = cur_w_q;
		case (state_q)
			hiq_pkg::S_IDLE: begin
				item_take = item_valid;
				if (item_valid && item.op == hiq_pkg::OP_APPEND && item.id_ok && !full) begin
					hp_we = 1'b1;
					hp_waddr = PW'(cnt_q);
					hp_wid = item.id;
					hp_ww = w_in;
				end
			end
			hiq_pkg::S_HF_RD: hp_raddr = hi_q;
			hiq_pkg::S_DN: hp_raddr = kid[PW-1:0];
			hiq_pkg::S_DN_K: begin
				if (right_in) begin
					hp_raddr = right[PW-1:0];
				end else begin
					hp_we = 1'b1;
					hp_wid = hid_rd_q;
					hp_ww = hw_rd_q;
				end
			end
			hiq_pkg::S_DN_R: begin
				hp_we = 1'b1;
				hp_wid = take_right ? hid_rd_q : kd_id_q;
				hp_ww = take_right ? hw_rd_q : kd_w_q;
			end
			hiq_pkg::S_UP: begin
				if (pos_q > start_q) begin
					hp_raddr = par;
				end else begin
					hp_we = 1'b1;
				end
			end
			hiq_pkg::S_UP_CMP: begin
				hp_we = 1'b1;
				if (up_less) begin
					hp_wid = hid_rd_q;
					hp_ww = hw_rd_q;
				end
			end
			hiq_pkg::S_PK: hp_raddr = PW'(cnt_m1);
			hiq_pkg::S_DC_POS: hp_raddr = pm_rd_q;
			default: hp_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hp_we) begin
			hid_mem[hp_waddr] <= hp_wid;
			hw_mem[hp_waddr] <= hp_ww;
			pm_mem[IDW'(hp_wid)] <= hp_waddr;
		end
		hid_rd_q <= hid_mem[hp_raddr];
		hw_rd_q <= hw_mem[hp_raddr];
		pm_rd_q <= pm_mem[pm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hiq_pkg::S_IDLE;
			cnt_q <= '0;
			present_q <= '0;
			hf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sift_end && hf_q && hi_q == '0) begin
				hf_q <= 1'b0;
			end
			case (state_q)
				hiq_pkg::S_IDLE: begin
					if (item_valid) begin
						hf_q <= item.op == hiq_pkg::OP_HEAPIFY && cnt_q != '0;
						if ((item.op == hiq_pkg::OP_INSERT || item.op == hiq_pkg::OP_APPEND) &&
							item.id_ok && !full) begin
							present_q[iid] <= 1'b1;
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				hiq_pkg::S_PK: begin
					if (is_pop_q) begin
						present_q[IDW'(hid_rd_q)] <= 1'b0;
						cnt_q <= cnt_m1;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sift_end && hf_q && hi_q != '0) begin
			hi_q <= hi_q - PW'(1);
		end
		case (state_q)
			hiq_pkg::S_IDLE: begin
				if (item_valid) begin
					stat_q <= hiq_pkg::ST_OK;
					oid_q <= '0;
					ow_q <= '0;
					cur_id_q <= item.id;
					cur_w_q <= w_in;
					pos_q <= PW'(cnt_q);
					start_q <= '0;
					hi_q <= PW'(half);
					is_pop_q <= item.op == hiq_pkg::OP_POP;
					case (item.op)
						hiq_pkg::OP_INSERT, hiq_pkg::OP_APPEND: begin
							if (!item.id_ok) begin
								stat_q <= hiq_pkg::ST_ABSENT;
							end else if (full) begin
								stat_q <= hiq_pkg::ST_FULL;
							end
						end
						hiq_pkg::OP_POP, hiq_pkg::OP_PEEK: begin
							if (cnt_q == '0) begin
								stat_q <= hiq_pkg::ST_EMPTY;
							end
						end
						hiq_pkg::OP_DECREASE: begin
							if (!item.id_ok || !present_q[iid]) begin
								stat_q <= hiq_pkg::ST_ABSENT;
							end
						end
						default: stat_q <= hiq_pkg::ST_OK;
					endcase
				end
			end
			hiq_pkg::S_HF_LD: begin
				cur_id_q <= hid_rd_q;
				cur_w_q <= hw_rd_q;
				pos_q <= hi_q;
				start_q <= hi_q;
			end
			hiq_pkg::S_DN_K: begin
				kd_id_q <= hid_rd_q;
				kd_w_q <= hw_rd_q;
				if (!right_in) begin
					pos_q <= kid[PW-1:0];
				end
			end
			hiq_pkg::S_DN_R: pos_q <= take_right ? right[PW-1:0] : kid[PW-1:0];
			hiq_pkg::S_UP_CMP: begin
				if (up_less) begin
					pos_q <= par;
				end
			end
			hiq_pkg::S_PK: begin
				oid_q <= hid_rd_q;
				ow_q <= hw_rd_q;
			end
			hiq_pkg::S_PP_LD: begin
				cur_id_q <= hid_rd_q;
				cur_w_q <= hw_rd_q;
				pos_q <= '0;
				start_q <= '0;
			end
			hiq_pkg::S_DC_POS: begin
				pos_q <= pm_rd_q;
				if (CW'(pm_rd_q) >= cnt_q) begin
					stat_q <= hiq_pkg::ST_ABSENT;
				end
			end
			hiq_pkg::S_DC_CHK: begin
				if (hid_rd_q != cur_id_q) begin
					stat_q <= hiq_pkg::ST_ABSENT;
				end else if (cur_w_q > hw_rd_q) begin
					stat_q <= hiq_pkg::ST_INCREASE;
				end
			end
			default: kd_id_q <= kd_id_q;
		endcase
	end

	assign ow64 = 64'(ow_q);
	assign done = state_q == hiq_pkg::S_FIN;
	assign status = stat_q;
	assign out_id = oid_q;
	assign out_weight = ow64[hiq_pkg::IN_W_BITS-1:0];
	assign count = cnt_q;
	assign is_empty = cnt_q == '0;

endmodule

@@ hdl/indexed_min_heap_queue.sv @@
// Top level of the indexed min-heap queue: front queue and heap back end.
// Simple beats go from S_IDLE straight to S_FIN. A sift toward the root passes S_UP
// and S_UP_CMP each level; leaf-ward, S_DN, S_DN_K and, with a right child, S_DN_R.
// Heapify runs one leaf-ward sift for each slot from count/2 down to 0.
// Throughput is one beat per back-end execution; a two-entry queue hides the front.
// Reset empties the heap and the queue at once; the result port cannot be stalled.
module indexed_min_heap_queue #(
	parameter int CAPACITY = 256,
	parameter int ID_COUNT = 256,
	parameter int WEIGHT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [hiq_pkg::ACT_BITS-1:0] action,
	input logic [hiq_pkg::ID_BITS-1:0] entry_id,
	input logic [hiq_pkg::IN_W_BITS-1:0] weight,
	output logic done,
	output logic [2:0] status,
	output logic [hiq_pkg::ID_BITS-1:0] out_id,
	output logic [hiq_pkg::IN_W_BITS-1:0] out_weight,
	output logic [$clog2(CAPACITY+1)-1:0] count,
	output logic is_empty
);
	hiq_pkg::item_t item;
	logic item_valid;
	logic item_take;

	hiq_front #(
		.ID_COUNT(ID_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(action),
		.entry_id(entry_id),
		.weight(weight),
		.busy(busy),
		.item(item),
		.item_valid(item_valid),
		.item_take(item_take)
	);

	hiq_back #(
		.CAPACITY(CAPACITY),
		.ID_COUNT(ID_COUNT),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_take(item_take),
		.done(done),
		.status(status),
		.out_id(out_id),
		.out_weight(out_weight),
		.count(count),
		.is_empty(is_empty)
	);

endmodule

@@ bench/indexed_min_heap_queue_tb.sv @@
// Self-checking testbench for the indexed min-heap queue: table, overfill, random beats.
module indexed_min_heap_queue_tb;

	typedef struct packed {
		hiq_pkg::status_t st;
		logic [7:0] oid;
		logic [31:0] ow;
		logic [8:0] cnt;
		logic emp;
	} answer_t;

	typedef struct packed {
		logic [2:0] act;
		logic [7:0] id;
		logic [31:0] w;
		logic typed;
		answer_t ans;
	} row_t;

	localparam int CAP = 256;
	localparam int STALL_LIMIT = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] action = '0;
	logic [7:0] entry_id = '0;
	logic [31:0] weight = '0;
	logic busy, done, is_empty;
	logic [2:0] status;
	logic [7:0] out_id;
	logic [31:0] out_weight;
	logic [8:0] count;

	indexed_min_heap_queue uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .entry_id(entry_id), .weight(weight),
		.done(done), .status(status), .out_id(out_id), .out_weight(out_weight),
		.count(count), .is_empty(is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow heap.
	logic [7:0] slot_id [CAP];
	logic [31:0] slot_w [CAP];
	int id_slot [256];
	bit id_held [256];
	int held_n;

	answer_t pending_answers [$];
	answer_t typed_answers [$];
	bit typed_flags [$];
	int errors, beats, answers, pops_hit, full_hits, stall_cycles;
	bit idle_on;

	function void place(logic [7:0] id, logic [31:0] w, int p);
		slot_id[p] = id;
		slot_w[p] = w;
		id_slot[id] = p;
	endfunction

	function void rise(int stop, int p);
		logic [7:0] id;
		logic [31:0] w;
		int par;
		id = slot_id[p];
		w = slot_w[p];
		while (p > stop) begin
			par = (p - 1) / 2;
			if (w < slot_w[par]) begin
				place(slot_id[par], slot_w[par], p);
				p = par;
			end else break;
		end
		place(id, w, p);
	endfunction

	function void sink(int p);
		int top, k;
		logic [7:0] id;
		logic [31:0] w;
		top = p;
		id = slot_id[p];
		w = slot_w[p];
		k = 2 * p + 1;
		while (k < held_n) begin
			if (k + 1 < held_n && !(slot_w[k] < slot_w[k + 1])) k = k + 1;
			place(slot_id[k], slot_w[k], p);
			p = k;
			k = 2 * p + 1;
		end
		place(id, w, p);
		rise(top, p);
	endfunction

	function answer_t heap_step(logic [2:0] act, logic [7:0] id, logic [31:0] w);
		answer_t a;
		int p;
		a = '0;
		a.st = hiq_pkg::ST_OK;
		case (act)
			hiq_pkg::ACT_INSERT, hiq_pkg::ACT_APPEND: begin
				if (held_n >= CAP) begin
					a.st = hiq_pkg::ST_FULL;
				end else begin
					place(id, w, held_n);
					id_held[id] = 1'b1;
					held_n++;
					if (act == hiq_pkg::ACT_INSERT) rise(0, held_n - 1);
				end
			end
			hiq_pkg::ACT_HEAPIFY: begin
				if (held_n > 0)
					for (int i = held_n / 2; i >= 0; i--) sink(i);
			end
			hiq_pkg::ACT_POP, hiq_pkg::ACT_PEEK: begin
				if (held_n == 0) begin
					a.st = hiq_pkg::ST_EMPTY;
				end else begin
					a.oid = slot_id[0];
					a.ow = slot_w[0];
					if (act == hiq_pkg::ACT_POP) begin
						id_held[a.oid] = 1'b0;
						held_n--;
						if (held_n > 0) begin
							place(slot_id[held_n], slot_w[held_n], 0);
							sink(0);
						end
					end
				end
			end
			hiq_pkg::ACT_DECREASE: begin
				if (!id_held[id]) begin
					a.st = hiq_pkg::ST_ABSENT;
				end else begin
					p = id_slot[id];
					if (p >= held_n || slot_id[p] != id) a.st = hiq_pkg::ST_ABSENT;
					else if (w > slot_w[p]) a.st = hiq_pkg::ST_INCREASE;
					else begin
						slot_w[p] = w;
						rise(0, p);
					end
				end
			end
			default: ;
		endcase
		a.cnt = held_n[8:0];
		a.emp = (held_n == 0);
		return a;
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Acceptance, prediction and checking all on the rising edge.
	always @(posedge clk) begin
		answer_t e, t;
		if (arst_n) begin
			if (done) begin
				answers++;
				if (pending_answers.size() == 0) begin
					report("unexpected beat", 32'(status), 32'd0);
				end else begin
					e = pending_answers.pop_front();
					if (status !== e.st) report("status", 32'(status), 32'(e.st));
					if (out_id !== e.oid) report("out_id", 32'(out_id), 32'(e.oid));
					if (out_weight !== e.ow) report("out_weight", out_weight, e.ow);
					if (count !== e.cnt) report("count", 32'(count), 32'(e.cnt));
					if (is_empty !== e.emp) report("is_empty", 32'(is_empty), 32'(e.emp));
				end
			end
			if (start && !busy) begin
				beats++;
				e = heap_step(action, entry_id, weight);
				t = typed_answers.pop_front();
				if (typed_flags.pop_front()) e = t;
				if (e.st == hiq_pkg::ST_FULL) full_hits++;
				if (action == hiq_pkg::ACT_POP && e.st == hiq_pkg::ST_OK) pops_hit++;
				pending_answers.push_back(e);
			end
			if (done || (start && !busy)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task send(logic [2:0] act, logic [7:0] id, logic [31:0] w, bit typed, answer_t ans);
		if (idle_on)
			while ($urandom_range(0, 99) < 26) begin
				@(negedge clk);
				start <= 1'b0;
				entry_id <= 8'($urandom);
				weight <= $urandom;
			end
		@(negedge clk);
		typed_answers.push_back(ans);
		typed_flags.push_back(typed);
		start <= 1'b1;
		action <= act;
		entry_id <= id;
		weight <= w;
		#1;
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	function logic [31:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return {2'($urandom_range(0, 3)), 30'h0};
			default: return $urandom;
		endcase
	endfunction

	task random_beat(bit well_formed);
		logic [7:0] id;
		logic [31:0] w;
		int r;
		id = well_formed ? 8'($urandom_range(0, 31)) : 8'($urandom);
		w = pick_weight();
		r = $urandom_range(0, 99);
		if (!well_formed) send(3'($urandom), id, w, 1'b0, '0);
		else if (r < 30) send(hiq_pkg::ACT_INSERT, id, w, 1'b0, '0);
		else if (r < 40) send(hiq_pkg::ACT_APPEND, id, w, 1'b0, '0);
		else if (r < 44) send(hiq_pkg::ACT_HEAPIFY, id, w, 1'b0, '0);
		else if (r < 64) send(hiq_pkg::ACT_POP, id, w, 1'b0, '0);
		else if (r < 72) send(hiq_pkg::ACT_PEEK, id, w, 1'b0, '0);
		else begin
			if (id_held[id] && $urandom_range(0, 9) < 8)
				w = $urandom_range(0, slot_w[id_slot[id] % CAP]);
			send(hiq_pkg::ACT_DECREASE, id, w, 1'b0, '0);
		end
	endtask

	function row_t mk(logic [2:0] a, logic [7:0] i, logic [31:0] w, bit ty,
			hiq_pkg::status_t st, logic [7:0] oi, logic [31:0] ow, int c);
		row_t r;
		r.act = a; r.id = i; r.w = w; r.typed = ty;
		r.ans.st = st; r.ans.oid = oi; r.ans.ow = ow;
		r.ans.cnt = c[8:0]; r.ans.emp = (c == 0);
		return r;
	endfunction

	row_t rows [$];

	initial begin
		for (int i = 0; i < 256; i++) begin
			id_held[i] = 1'b0;
			id_slot[i] = 0;
		end
		held_n = 0;
		errors = 0; beats = 0; answers = 0; pops_hit = 0; full_hits = 0; stall_cycles = 0;
		idle_on = 1'b1;
		rows.push_back(mk(hiq_pkg::ACT_POP, 0, 0, 1, hiq_pkg::ST_EMPTY, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_PEEK, 0, 0, 1, hiq_pkg::ST_EMPTY, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_HEAPIFY, 0, 0, 1, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_DECREASE, 7, 0, 1, hiq_pkg::ST_ABSENT, 0, 0, 0));
		rows.push_back(mk(3'd6, 8'hFF, '1, 1, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(3'd7, 0, 0, 1, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_INSERT, 0, 32'hFFFFFFFF, 1, hiq_pkg::ST_OK, 0, 0, 1));
		rows.push_back(mk(hiq_pkg::ACT_INSERT, 255, 0, 1, hiq_pkg::ST_OK, 0, 0, 2));
		rows.push_back(mk(hiq_pkg::ACT_PEEK, 0, 0, 1, hiq_pkg::ST_OK, 255, 0, 2));
		rows.push_back(mk(hiq_pkg::ACT_APPEND, 17, 5, 0, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_DECREASE, 0, 32'hFFFFFFFF, 1, hiq_pkg::ST_OK, 0, 0, 3));
		rows.push_back(mk(hiq_pkg::ACT_DECREASE, 17, 6, 1, hiq_pkg::ST_INCREASE, 0, 0, 3));
		rows.push_back(mk(hiq_pkg::ACT_DECREASE, 17, 0, 0, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_INSERT, 17, 0, 0, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_APPEND, 40, 32'h80000000, 0, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_HEAPIFY, 0, 0, 0, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_POP, 0, 0, 0, hiq_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(hiq_pkg::ACT_DECREASE, 17, 0, 0, hiq_pkg::ST_OK, 0, 0, 0));
		for (int i = 0; i < 6; i++)
			rows.push_back(mk(hiq_pkg::ACT_POP, 0, 0, 0, hiq_pkg::ST_OK, 0, 0, 0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) send(rows[i].act, rows[i].id, rows[i].w, rows[i].typed, rows[i].ans);

		// Fill past capacity, then let the queue drain before going on.
		for (int i = 0; i < 262; i++)
			send(($urandom_range(0, 1) ? hiq_pkg::ACT_INSERT : hiq_pkg::ACT_APPEND),
				8'($urandom), pick_weight(), 1'b0, '0);
		send(hiq_pkg::ACT_HEAPIFY, 0, 0, 1'b0, '0);
		send(hiq_pkg::ACT_DECREASE, 8'($urandom), 0, 1'b0, '0);
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		for (int i = 0; i < 100; i++) send(hiq_pkg::ACT_POP, 0, 0, 1'b0, '0);

		for (int i = 0; i < 110; i++) begin
			idle_on = !(i >= 30 && i < 80);
			random_beat($urandom_range(0, 99) < 88);
		end
		send(hiq_pkg::ACT_PEEK, 0, 0, 1'b0, '0);

		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_answers.size() != 0) begin
			report("beats left over", pending_answers.size(), 0);
		end
		$display("covered %0d accepted beats and %0d checked results", beats, answers);
		$display("%0d pops returned an entry, %0d beats hit a full heap", pops_hit, full_hits);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

@@ sim.f @@
hdl/hiq_pkg.sv
hdl/hiq_front.sv
hdl/hiq_back.sv
hdl/indexed_min_heap_queue.sv
bench/indexed_min_heap_queue_tb.sv
